FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the RTL, clocked on aclk and held off in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge of aclk outside reset
`define CHK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// property checked in the cycle after its trigger
`define CHK_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (prop)) \
        else $error(msg);

`endif

FILE: rtl/pho_pkg.sv
// ----------------------------------------------------------------------------
// pho_pkg
// Shared widths, constants and types of the pixel halo outline block
// ----------------------------------------------------------------------------
package pho_pkg;

    localparam int ROW_W         = 64;
    localparam int CFG_W         = 7;
    localparam int MAX_WIDTH_DEF = 64;
    localparam logic [CFG_W-1:0] RESET_WIDTH = 7'd64;

    // in: fg_row, mark_row; out: out_fg_row, halo_row
    localparam int TDATA_W = 2 * ROW_W;

    // result buffer
    localparam int BUF_DEPTH = 4;
    localparam int BUF_PTR_W = $clog2(BUF_DEPTH);
    localparam int BUF_CNT_W = $clog2(BUF_DEPTH + 1);

    typedef logic [ROW_W-1:0] row_t;

    typedef struct packed {
        logic end_of_bitmap;
        row_t halo_row;
        row_t out_fg_row;
    } res_t;

endpackage

FILE: rtl/pixel_halo_outline.sv
// ----------------------------------------------------------------------------
// pixel_halo_outline
// 3x3 binary dilation halo over a bitmap streamed one row per transfer
// ----------------------------------------------------------------------------
// One row is taken per cycle. A row's result is written to the output buffer
// in the cycle its lower neighbor is taken, and can reach the master side
// from the cycle after; a row flagged with tlast is written together with its
// predecessor, so that transfer can add two results. The four-entry result
// buffer sets the input side: s_tready is high while two entries are free,
// which keeps one row per cycle as long as the master side drains one result
// per cycle. row_width is taken from cfg_wr_data on any cycle with cfg_wr_en.
module pixel_halo_outline #(
    parameter int MAX_WIDTH = pho_pkg::MAX_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // config
    input  logic                        cfg_wr_en,
    input  logic [pho_pkg::CFG_W-1:0]   cfg_wr_data,   // row_width
    // row input
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [pho_pkg::TDATA_W-1:0] s_tdata,       // fg_row, mark_row
    input  logic                        s_tlast,       // last_row
    // result output
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [pho_pkg::TDATA_W-1:0] m_tdata,       // out_fg_row, halo_row
    output logic                        m_tlast        // end_of_bitmap
);
    import pho_pkg::*;
`include "assert_macros.svh"

    logic [CFG_W-1:0] width_reg;
    row_t held_fg_reg, held_fg_next;
    row_t held_mark_reg, held_mark_next;
    row_t above_fg_reg, above_fg_next;
    logic held_valid_reg, held_valid_next;

    logic [CFG_W-1:0] width_eff;
    row_t width_mask;
    row_t in_fg;
    row_t in_mark;
    row_t above_after;
    row_t halo_held;
    row_t halo_last;
    logic s_fire;
    logic m_fire;
    logic push0;
    logic push1;
    res_t res0;
    res_t res1;
    res_t out_res;
    logic buf_room;
    logic [BUF_CNT_W-1:0] buf_count;

    assign in_fg   = s_tdata[ROW_W-1:0];
    assign in_mark = s_tdata[TDATA_W-1:ROW_W];
    assign s_fire  = s_tvalid && s_tready;
    assign m_fire  = m_tvalid && m_tready;

    // clamp the width to 1..MAX_WIDTH and build the column mask
    always_comb begin
        if (width_reg == '0) begin
            width_eff = CFG_W'(1);
        end else if (width_reg > CFG_W'(MAX_WIDTH)) begin
            width_eff = CFG_W'(MAX_WIDTH);
        end else begin
            width_eff = width_reg;
        end
        for (int i = 0; i < ROW_W; i++) begin
            width_mask[i] = (CFG_W'(i) < width_eff);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= RESET_WIDTH;
        end else if (cfg_wr_en) begin
            width_reg <= cfg_wr_data;
        end
    end

    assign above_after = held_valid_reg ? held_fg_reg : above_fg_reg;

    pho_halo u_halo_held (
        .up_row     (above_fg_reg),
        .mid_row    (held_fg_reg),
        .down_row   (in_fg),
        .mark_row   (held_mark_reg),
        .width_mask (width_mask),
        .halo_row   (halo_held)
    );

    pho_halo u_halo_last (
        .up_row     (above_after),
        .mid_row    (in_fg),
        .down_row   ('0),
        .mark_row   (in_mark),
        .width_mask (width_mask),
        .halo_row   (halo_last)
    );

    always_comb begin
        res0.out_fg_row    = held_fg_reg;
        res0.halo_row      = halo_held;
        res0.end_of_bitmap = 1'b0;
        res1.out_fg_row    = in_fg;
        res1.halo_row      = halo_last;
        res1.end_of_bitmap = 1'b1;
        push0 = s_fire && held_valid_reg;
        push1 = s_fire && s_tlast;
    end

    always_comb begin
        held_fg_next    = held_fg_reg;
        held_mark_next  = held_mark_reg;
        above_fg_next   = above_fg_reg;
        held_valid_next = held_valid_reg;
        if (s_fire) begin
            if (s_tlast) begin
                // end of bitmap: next transfer starts a fresh one
                held_fg_next    = '0;
                held_mark_next  = '0;
                above_fg_next   = '0;
                held_valid_next = 1'b0;
            end else begin
                held_fg_next    = in_fg;
                held_mark_next  = in_mark;
                above_fg_next   = above_after;
                held_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_fg_reg    <= '0;
            held_mark_reg  <= '0;
            above_fg_reg   <= '0;
            held_valid_reg <= 1'b0;
        end else begin
            held_fg_reg    <= held_fg_next;
            held_mark_reg  <= held_mark_next;
            above_fg_reg   <= above_fg_next;
            held_valid_reg <= held_valid_next;
        end
    end

    pho_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en0    (push0),
        .wr_data0  (res0),
        .wr_en1    (push1),
        .wr_data1  (res1),
        .rd_en     (m_fire),
        .rd_data   (out_res),
        .not_empty (m_tvalid),
        .room_two  (buf_room),
        .count     (buf_count)
    );

    assign s_tready = buf_room;
    assign m_tdata  = {out_res.halo_row, out_res.out_fg_row};
    assign m_tlast  = out_res.end_of_bitmap;

    `CHK_ALWAYS(a_buf_bound, buf_count <= BUF_CNT_W'(BUF_DEPTH), "result buffer overflow")
    `CHK_NEXT(a_last_clears, s_fire && s_tlast, !held_valid_reg && (above_fg_reg == '0), "bitmap end did not clear held state")
    `CHK_NEXT(a_one_result, s_fire && held_valid_reg && !s_tlast && !m_fire, buf_count == $past(buf_count) + BUF_CNT_W'(1), "held row result not queued")

endmodule

FILE: rtl/pho_halo.sv
// ----------------------------------------------------------------------------
// pho_halo
// 3x3 dilation of one row against its upper and lower neighbors, plus own mark
// ----------------------------------------------------------------------------
module pho_halo (
    input  pho_pkg::row_t up_row,
    input  pho_pkg::row_t mid_row,
    input  pho_pkg::row_t down_row,
    input  pho_pkg::row_t mark_row,
    input  pho_pkg::row_t width_mask,
    output pho_pkg::row_t halo_row
);
    import pho_pkg::*;

    row_t up_m;
    row_t down_m;
    row_t any_m;

    always_comb begin
        up_m   = up_row & width_mask;
        down_m = down_row & width_mask;
        any_m  = up_m | (mid_row & width_mask) | down_m;
        // horizontal neighbors from any row, vertical ones from up and down
        halo_row = ((any_m << 1) | (any_m >> 1) | up_m | down_m | mark_row) & width_mask;
    end

endmodule

FILE: rtl/pho_out_fifo.sv
// ----------------------------------------------------------------------------
// pho_out_fifo
// Small result buffer taking up to two results per cycle, giving one
// ----------------------------------------------------------------------------
module pho_out_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_en0,
    input  pho_pkg::res_t wr_data0,
    input  logic          wr_en1,
    input  pho_pkg::res_t wr_data1,
    input  logic          rd_en,
    output pho_pkg::res_t rd_data,
    output logic          not_empty,
    output logic          room_two,
    output logic [pho_pkg::BUF_CNT_W-1:0] count
);
    import pho_pkg::*;

    res_t mem [BUF_DEPTH];

    logic [BUF_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [BUF_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [BUF_CNT_W-1:0] count_reg, count_next;
    logic [BUF_PTR_W-1:0] slot1;

    // second result lands after the first when both are present
    assign slot1 = wr_en0 ? (wr_ptr_reg + BUF_PTR_W'(1)) : wr_ptr_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + BUF_PTR_W'(wr_en0) + BUF_PTR_W'(wr_en1);
        rd_ptr_next = rd_ptr_reg + BUF_PTR_W'(rd_en);
        count_next  = count_reg + BUF_CNT_W'(wr_en0) + BUF_CNT_W'(wr_en1)
                      - BUF_CNT_W'(rd_en);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en0) begin
            mem[wr_ptr_reg] <= wr_data0;
        end
        if (wr_en1) begin
            mem[slot1] <= wr_data1;
        end
    end

    assign rd_data   = mem[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign room_two  = (count_reg <= BUF_CNT_W'(BUF_DEPTH - 2));
    assign count     = count_reg;

endmodule

FILE: dv/halo_row_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// halo_row_checker
// Watches the row and result channels of the halo outline block, predicts the
// result rows of every accepted row transfer and compares them field by field
// ----------------------------------------------------------------------------
module halo_row_checker
    import pho_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [CFG_W-1:0]   cfg_wr_data,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,
    input  logic               s_tlast,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [TDATA_W-1:0] m_tdata,
    input  logic               m_tlast,
    output int                 fail_count,
    output int                 rows_due
);

    logic [CFG_W-1:0] width_q;
    row_t             held_fg_q;
    row_t             held_mark_q;
    row_t             upper_fg_q;
    logic             held_q;
    res_t             due_rows[$];

    function automatic row_t column_mask(logic [CFG_W-1:0] w);
        int n;
        n = (w == 0) ? 1 : int'(w);
        if (n > MAX_WIDTH_DEF)
            n = MAX_WIDTH_DEF;
        if (n >= ROW_W)
            return '1;
        return (row_t'(1) << n) - row_t'(1);
    endfunction

    function automatic row_t dilate(row_t up, row_t mid, row_t down, row_t mark, row_t m);
        row_t a;
        row_t b;
        row_t any_fg;
        a = up & m;
        b = down & m;
        any_fg = a | b | (mid & m);
        return ((any_fg << 1) | (any_fg >> 1) | a | b | (mark & m)) & m;
    endfunction

    task automatic flag_field(string field, logic [ROW_W-1:0] want, logic [ROW_W-1:0] got);
        fail_count++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
    endtask

    always @(posedge aclk) begin
        res_t got;
        res_t want;
        row_t fg;
        row_t mark;
        row_t m;
        if (!aresetn) begin
            width_q     = RESET_WIDTH;
            held_fg_q   = '0;
            held_mark_q = '0;
            upper_fg_q  = '0;
            held_q      = 1'b0;
            due_rows.delete();
            fail_count  = 0;
        end else begin
            if (cfg_wr_en)
                width_q = cfg_wr_data;

            if (m_tvalid && m_tready) begin
                got = {m_tlast, m_tdata};
                if (due_rows.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none actual %h",
                             $time, got);
                end else begin
                    want = due_rows.pop_front();
                    if (got.out_fg_row !== want.out_fg_row)
                        flag_field("out_fg_row", want.out_fg_row, got.out_fg_row);
                    if (got.halo_row !== want.halo_row)
                        flag_field("halo_row", want.halo_row, got.halo_row);
                    if (got.end_of_bitmap !== want.end_of_bitmap)
                        flag_field("end_of_bitmap", ROW_W'(want.end_of_bitmap),
                                   ROW_W'(got.end_of_bitmap));
                end
            end

            if (s_tvalid && s_tready) begin
                fg   = s_tdata[ROW_W-1:0];
                mark = s_tdata[TDATA_W-1:ROW_W];
                m    = column_mask(width_q);
                // the held row is finished by the row below it
                if (held_q) begin
                    want.out_fg_row    = held_fg_q;
                    want.halo_row      = dilate(upper_fg_q, held_fg_q, fg, held_mark_q, m);
                    want.end_of_bitmap = 1'b0;
                    due_rows.push_back(want);
                    upper_fg_q = held_fg_q;
                end
                if (s_tlast) begin
                    want.out_fg_row    = fg;
                    want.halo_row      = dilate(upper_fg_q, fg, '0, mark, m);
                    want.end_of_bitmap = 1'b1;
                    due_rows.push_back(want);
                    held_fg_q   = '0;
                    held_mark_q = '0;
                    upper_fg_q  = '0;
                    held_q      = 1'b0;
                end else begin
                    held_fg_q   = fg;
                    held_mark_q = mark;
                    held_q      = 1'b1;
                end
            end
        end
        rows_due = due_rows.size();
    end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams bitmaps row by row into the halo outline block under several row
// widths and idle patterns on both channels; a checker beside the block
// predicts every result row and counts mismatches for the final verdict
// ----------------------------------------------------------------------------
module testbench;
    import pho_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_PHASES  = 9;
    localparam int PHASE_ROWS  = 183;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]   cfg_wr_data = '0;
    logic               s_tvalid    = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata     = '0;
    logic               s_tlast     = 1'b0;
    logic               m_tvalid;
    logic               m_tready    = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tlast;

    int fail_count;
    int rows_due;
    int cycle_count   = 0;
    int send_gap_pct  = 0;
    int recv_stall_pct = 0;
    int cur_width     = 64;
    int phase_width[NUM_PHASES] = '{0, 127, 1, 64, 2, 65, 63, 5, 33};

    always #4 aclk = ~aclk;

    pixel_halo_outline u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    halo_row_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .rows_due    (rows_due)
    );

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic row_t pick_row(int w);
        row_t r;
        int   e;
        e = (w == 0) ? 1 : ((w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w);
        case ($urandom_range(9))
            0: r = '0;
            1: r = '1;
            2, 3: r = {$urandom, $urandom};
            4, 5: r = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            6: r = row_t'(1) << $urandom_range(ROW_W - 1);
            // columns at both edges and just past the width
            7: r = (row_t'(1) << (e - 1)) | row_t'($urandom_range(1))
                   | (row_t'($urandom_range(1)) << e);
            default: r = ~({$urandom, $urandom} & {$urandom, $urandom});
        endcase
        return r;
    endfunction

    task automatic push_row(row_t fg, row_t mark, logic last);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom, $urandom, $urandom};
            s_tlast  <= 1'($urandom_range(1));
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {mark, fg};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic set_width(int w);
        s_tvalid <= 1'b0;
        wait (rows_due == 0);
        repeat (4) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CFG_W'(w);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cur_width = w;
    endtask

    task automatic run_phase(int n);
        int   sent;
        int   len;
        bit   paused;
        row_t fg;
        row_t mark;
        sent   = 0;
        paused = 0;
        while (sent < n) begin
            case ($urandom_range(9))
                0: len = 1;
                1: len = $urandom_range(20, 40);
                default: len = $urandom_range(2, 10);
            endcase
            for (int r = 0; r < len; r++) begin
                // hold off midway through the phase until the result side is empty
                if (!paused && sent >= n / 2) begin
                    paused = 1;
                    s_tvalid <= 1'b0;
                    wait (rows_due == 0);
                    @(negedge aclk);
                end
                fg   = pick_row(cur_width);
                mark = ($urandom_range(3) == 0) ? pick_row(cur_width) : '0;
                push_row(fg, mark, r == len - 1);
                sent++;
            end
        end
        s_tvalid <= 1'b0;
    endtask

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // full width: single-row bitmaps, edge columns, alternating columns
        push_row('1, '0, 1'b1);
        push_row('0, '1, 1'b1);
        push_row(row_t'(1), '0, 1'b0);
        push_row(row_t'(1) << (ROW_W - 1), '0, 1'b0);
        push_row('0, (row_t'(1) << (ROW_W - 1)) | row_t'(1), 1'b1);
        push_row({32{2'b10}}, '0, 1'b0);
        push_row({32{2'b01}}, '0, 1'b1);
        s_tvalid <= 1'b0;

        // narrow rows: bits past the width must not count
        set_width(5);
        push_row('1, '1, 1'b1);
        push_row(~row_t'(5'h1f), ~row_t'(5'h1f), 1'b0);
        push_row(row_t'(5'h10), '0, 1'b0);
        push_row('0, '0, 1'b1);
        s_tvalid <= 1'b0;

        set_width(1);
        push_row('1, '0, 1'b0);
        push_row('0, row_t'(2'b11), 1'b0);
        push_row(row_t'(2'b10), '0, 1'b1);
        s_tvalid <= 1'b0;

        phase_width[NUM_PHASES - 1] = $urandom_range(3, 62);
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_width(phase_width[p]);
            if (p < 3) begin
                send_gap_pct   = 7;
                recv_stall_pct = 62;
            end else if (p < 6) begin
                send_gap_pct   = 62;
                recv_stall_pct = 7;
            end else begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            run_phase(PHASE_ROWS);
        end

        wait (rows_due == 0);
        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: pixel_halo_outline.f
+incdir+rtl
rtl/pho_pkg.sv
rtl/pho_halo.sv
rtl/pho_out_fifo.sv
rtl/pixel_halo_outline.sv
dv/halo_row_checker.sv
dv/testbench.sv
